FILE: hw/rtl/lcdpkt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcdpkt_pkg: shared types and constants for the LCD expander packet generator
// Word formats, request modes, register indexes and the init nibble table.
// ---------------------------------------------------------------------------
package lcdpkt_pkg;

   typedef enum logic [1:0] {
      MODE_COMMAND = 2'd0,
      MODE_CHAR    = 2'd1,
      MODE_CURSOR  = 2'd2,
      MODE_INIT    = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type   mode;
      logic [7:0] value;
      logic [7:0] row;
      logic [7:0] column;
      logic       deep_clear;
   } req_type;

   typedef struct packed {
      logic [7:0] address_byte;
      logic [7:0] expander_byte;
      logic       last;
   } rsp_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;

   localparam logic [CSR_INDEX_W-1:0] CSR_LCD_ADDRESS     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKLIGHT_ON    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_PRESENT = 2'd2;

   localparam logic [6:0] RESET_LCD_ADDRESS     = 7'd39;
   localparam logic       RESET_BACKLIGHT_ON    = 1'b1;
   localparam logic       RESET_DISPLAY_PRESENT = 1'b1;

   // packet index within one request
   localparam int PKT_IDX_W = 5;
   localparam logic [PKT_IDX_W-1:0] LAST_IDX_BYTE       = 5'd3;
   localparam logic [PKT_IDX_W-1:0] LAST_IDX_INIT       = 5'd19;
   localparam logic [PKT_IDX_W-1:0] LAST_IDX_INIT_CLEAR = 5'd23;

   localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

   function automatic logic [7:0] row_offset(input logic [1:0] r);
      logic [7:0] off;
      begin
         case (r)
            2'd0:    off = 8'h00;
            2'd1:    off = 8'h40;
            2'd2:    off = 8'h14;
            default: off = 8'h54;
         endcase
         return off;
      end
   endfunction

   // nibble n of the init sequence: reset nibbles 3,3,3,2 then
   // commands 0x28, 0x0C, 0x06, 0x01 high nibble first
   function automatic logic [3:0] init_nibble(input logic [3:0] n);
      logic [3:0] nib;
      begin
         case (n)
            4'd0, 4'd1, 4'd2: nib = 4'h3;
            4'd3:             nib = 4'h2;
            4'd4:             nib = 4'h2;
            4'd5:             nib = 4'h8;
            4'd6:             nib = 4'h0;
            4'd7:             nib = 4'hC;
            4'd8:             nib = 4'h0;
            4'd9:             nib = 4'h6;
            4'd10:            nib = 4'h0;
            4'd11:            nib = 4'h1;
            default:          nib = 4'h0;
         endcase
         return nib;
      end
   endfunction

endpackage

FILE: hw/rtl/char_lcd_expander_packet_gen_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// char_lcd_expander_packet_gen_unit: character LCD packet generator
// Turns LCD requests into address/expander byte packets for a 4-bit panel.
// ---------------------------------------------------------------------------
// Usage:
//   req_* takes one request word (command, character, cursor move or init).
//   rsp_* gives one packet word per unstalled cycle: address byte, expander
//   byte and a last flag on the final packet of the request. csr_* writes the
//   bus address, backlight bit and display-present bit; write only while idle.
// Sequencing: a taken request loads the sequencer registers, and each packet
//   passes through the output register. Command, character and cursor requests
//   give 4 packets; init gives 20, or 24 with deep_clear, and none when no
//   display is present. The sequencer issues one packet per cycle while the
//   output is not stalled; the next request is taken in the cycle its
//   predecessor's last packet moves into the output register, so packets
//   stream without gaps.
// Reset: clears the sequencer and output valid, and loads the register
//   defaults (address 39, backlight on, display present).
// Stall: rsp_stall holds the output word; the sequencer and req_stall wait.
// ---------------------------------------------------------------------------
module char_lcd_expander_packet_gen_unit
   import lcdpkt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_payload,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [6:0] lcd_address_ff;
   logic       backlight_on_ff;
   logic       display_present_ff;

   logic                 busy_ff, busy_in;
   logic [PKT_IDX_W-1:0] idx_ff, idx_in;
   logic [PKT_IDX_W-1:0] last_idx_ff, last_idx_in;
   logic                 is_init_ff, is_init_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 rs_ff, rs_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_payload_ff, rsp_payload_in;

   logic       out_free, issue, issue_last, accept, load;
   logic [1:0] row_sel;
   logic [7:0] cursor_pos;
   logic [3:0] nib;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lcd_address_ff     <= RESET_LCD_ADDRESS;
         backlight_on_ff    <= RESET_BACKLIGHT_ON;
         display_present_ff <= RESET_DISPLAY_PRESENT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LCD_ADDRESS:     lcd_address_ff     <= csr_wdata;
            CSR_BACKLIGHT_ON:    backlight_on_ff    <= csr_wdata[0];
            CSR_DISPLAY_PRESENT: display_present_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      issue      = busy_ff && out_free;
      issue_last = issue && (idx_ff == last_idx_ff);
      req_stall  = busy_ff && !issue_last;
      accept     = req_valid && !req_stall;
      // init without a display gives no packets: drop it
      load       = accept && !((req_payload.mode == MODE_INIT) && !display_present_ff);

      row_sel    = (req_payload.row >= 8'd4) ? 2'd3 : req_payload.row[1:0];
      cursor_pos = req_payload.column + row_offset(row_sel);

      busy_in     = busy_ff;
      idx_in      = idx_ff;
      last_idx_in = last_idx_ff;
      is_init_in  = is_init_ff;
      byte_in     = byte_ff;
      rs_in       = rs_ff;

      if (issue_last) begin
         busy_in = 1'b0;
      end else if (issue) begin
         idx_in = idx_ff + 1'b1;
      end

      if (load) begin
         busy_in    = 1'b1;
         idx_in     = '0;
         is_init_in = (req_payload.mode == MODE_INIT);
         rs_in      = (req_payload.mode == MODE_CHAR);
         if (req_payload.mode == MODE_CURSOR) begin
            byte_in = CMD_SET_DDRAM | cursor_pos;
         end else begin
            byte_in = req_payload.value;
         end
         if (req_payload.mode == MODE_INIT) begin
            last_idx_in = req_payload.deep_clear ? LAST_IDX_INIT_CLEAR : LAST_IDX_INIT;
         end else begin
            last_idx_in = LAST_IDX_BYTE;
         end
      end

      // two packets per nibble: enable high, then enable low
      if (is_init_ff) begin
         nib = init_nibble(idx_ff[PKT_IDX_W-1:1]);
      end else begin
         nib = idx_ff[1] ? byte_ff[3:0] : byte_ff[7:4];
      end

      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (issue) begin
         rsp_valid_in                 = 1'b1;
         rsp_payload_in.address_byte  = {lcd_address_ff, 1'b0};
         rsp_payload_in.expander_byte = {nib, backlight_on_ff, ~idx_ff[0], 1'b0, rs_ff};
         rsp_payload_in.last          = (idx_ff == last_idx_ff);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      last_idx_ff    <= last_idx_in;
      is_init_ff     <= is_init_in;
      byte_ff        <= byte_in;
      rs_ff          <= rs_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

FILE: dv/char_lcd_expander_packet_gen_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// char_lcd_expander_packet_gen_unit_test: packet generator testbench
// Sends command, character, cursor and init requests under several register
// settings and random flow control. Each request is predicted locally as a
// list of expander packets, and every packet word is checked field by field.
// ---------------------------------------------------------------------------
module char_lcd_expander_packet_gen_unit_test;
   import lcdpkt_pkg::*;

   localparam int TIMEOUT_NS   = 2_000_000;
   localparam int SETTLE_TICKS = 8;
   localparam int ITEMS_PER_STEP = 72;

   localparam logic [3:0] NIB_WAKE     = 4'h3;
   localparam logic [3:0] NIB_FOUR_BIT = 4'h2;
   localparam logic [7:0] LCD_FUNCTION_SET = 8'h28;
   localparam logic [7:0] LCD_DISPLAY_ON   = 8'h0C;
   localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;
   localparam logic [7:0] LCD_CLEAR        = 8'h01;
   // DDRAM start of rows 0..3, row 0 in the low byte
   localparam logic [31:0] ROW_STARTS = {8'h54, 8'h14, 8'h40, 8'h00};

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_we      = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;

   // local copy of the registers
   logic [6:0] lcd_addr_reg   = RESET_LCD_ADDRESS;
   logic       backlight_reg  = RESET_BACKLIGHT_ON;
   logic       present_reg    = RESET_DISPLAY_PRESENT;

   rsp_type expected_packets[$];
   int      sender_idle_pct    = 0;
   int      receiver_stall_pct = 0;
   int      error_count        = 0;
   int      packets_checked    = 0;
   int      requests_by_mode[4] = '{0, 0, 0, 0};
   int      settings_applied   = 0;

   char_lcd_expander_packet_gen_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("status: fail");
      $finish;
   end

   // ---- packet prediction ----
   function automatic void push_nibble(input logic [3:0] nib, input logic rs,
                                       input logic fin);
      rsp_type pkt;
      begin
         pkt.address_byte  = {lcd_addr_reg, 1'b0};
         // nibble, backlight, enable, unused, RS
         pkt.expander_byte = {nib, backlight_reg, 1'b1, 1'b0, rs};
         pkt.last          = 1'b0;
         expected_packets.push_back(pkt);
         pkt.expander_byte[2] = 1'b0;
         pkt.last             = fin;
         expected_packets.push_back(pkt);
      end
   endfunction

   function automatic void push_byte(input logic [7:0] v, input logic rs,
                                     input logic fin);
      begin
         push_nibble(v[7:4], rs, 1'b0);
         push_nibble(v[3:0], rs, fin);
      end
   endfunction

   function automatic void predict_packets(input req_type r);
      logic [1:0] row_sel;
      logic [7:0] ddram_pos;
      begin
         case (r.mode)
            MODE_COMMAND: push_byte(r.value, 1'b0, 1'b1);
            MODE_CHAR:    push_byte(r.value, 1'b1, 1'b1);
            MODE_CURSOR: begin
               row_sel   = (r.row >= 8'd4) ? 2'd3 : r.row[1:0];
               ddram_pos = r.column + ROW_STARTS[8*int'(row_sel) +: 8];
               push_byte(CMD_SET_DDRAM | ddram_pos, 1'b0, 1'b1);
            end
            default: begin
               if (present_reg) begin
                  push_nibble(NIB_WAKE, 1'b0, 1'b0);
                  push_nibble(NIB_WAKE, 1'b0, 1'b0);
                  push_nibble(NIB_WAKE, 1'b0, 1'b0);
                  push_nibble(NIB_FOUR_BIT, 1'b0, 1'b0);
                  push_byte(LCD_FUNCTION_SET, 1'b0, 1'b0);
                  push_byte(LCD_DISPLAY_ON, 1'b0, 1'b0);
                  push_byte(LCD_ENTRY_MODE, 1'b0, !r.deep_clear);
                  if (r.deep_clear)
                     push_byte(LCD_CLEAR, 1'b0, 1'b1);
               end
            end
         endcase
         requests_by_mode[r.mode]++;
      end
   endfunction

   function automatic req_type make_request(input mode_type m, input logic [7:0] v,
                                            input logic [7:0] row,
                                            input logic [7:0] column,
                                            input logic deep);
      req_type r;
      begin
         r.mode       = m;
         r.value      = v;
         r.row        = row;
         r.column     = column;
         r.deep_clear = deep;
         return r;
      end
   endfunction

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(255));
   endfunction

   // ---- packet checker and receiver flow control ----
   always @(posedge clock) begin : check_packets
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_packets.size() == 0) begin
            $error("unexpected packet word: address %02h expander %02h last %0b",
                   rsp_payload.address_byte, rsp_payload.expander_byte,
                   rsp_payload.last);
            error_count++;
         end else begin
            want = expected_packets.pop_front();
            packets_checked++;
            if (rsp_payload.address_byte !== want.address_byte) begin
               $error("address_byte: expected %02h, got %02h",
                      want.address_byte, rsp_payload.address_byte);
               error_count++;
            end
            if (rsp_payload.expander_byte !== want.expander_byte) begin
               $error("expander_byte: expected %02h, got %02h",
                      want.expander_byte, rsp_payload.expander_byte);
               error_count++;
            end
            if (rsp_payload.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_payload.last);
               error_count++;
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // ---- request driver ----
   task automatic send_request(input req_type r);
      begin
         if ($urandom_range(99) < sender_idle_pct) begin
            req_valid <= 1'b0;
            do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
         end
         req_valid   <= 1'b1;
         req_payload <= r;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         predict_packets(r);
      end
   endtask

   // hold off until every expected packet is out, then let the block settle
   task automatic wait_for_drain();
      begin
         req_valid <= 1'b0;
         while (expected_packets.size() != 0) @(posedge clock);
         repeat (SETTLE_TICKS) @(posedge clock);
      end
   endtask

   task automatic apply_settings(input logic [6:0] addr, input logic bl,
                                 input logic present);
      begin
         wait_for_drain();
         csr_we    <= 1'b1;
         csr_index <= CSR_LCD_ADDRESS;
         csr_wdata <= addr;
         @(posedge clock);
         csr_index <= CSR_BACKLIGHT_ON;
         csr_wdata <= CSR_DATA_W'(bl);
         @(posedge clock);
         csr_index <= CSR_DISPLAY_PRESENT;
         csr_wdata <= CSR_DATA_W'(present);
         @(posedge clock);
         csr_we        <= 1'b0;
         lcd_addr_reg  = addr;
         backlight_reg = bl;
         present_reg   = present;
         settings_applied++;
      end
   endtask

   // ---- tests ----
   task automatic test_default_settings();
      begin
         send_request(make_request(MODE_COMMAND, 8'h00, any_byte(), any_byte(), 1'b1));
         send_request(make_request(MODE_COMMAND, 8'hFF, any_byte(), any_byte(), 1'b0));
         send_request(make_request(MODE_CHAR, 8'h00, any_byte(), any_byte(), 1'b0));
         send_request(make_request(MODE_CHAR, 8'hFF, any_byte(), any_byte(), 1'b1));
         send_request(make_request(MODE_CHAR, 8'h5A, any_byte(), any_byte(), 1'b0));
         send_request(make_request(MODE_CURSOR, any_byte(), 8'd0, 8'd0, 1'b1));
         send_request(make_request(MODE_CURSOR, any_byte(), 8'd1, 8'h27, 1'b0));
         send_request(make_request(MODE_CURSOR, any_byte(), 8'd2, 8'hFF, 1'b0));
         // row 3 offset plus column wraps past 0xFF
         send_request(make_request(MODE_CURSOR, any_byte(), 8'd3, 8'hAC, 1'b1));
         send_request(make_request(MODE_CURSOR, any_byte(), 8'd4, 8'h05, 1'b0));
         send_request(make_request(MODE_CURSOR, any_byte(), 8'hFF, 8'hFF, 1'b0));
         send_request(make_request(MODE_INIT, any_byte(), any_byte(), any_byte(), 1'b0));
         send_request(make_request(MODE_INIT, any_byte(), any_byte(), any_byte(), 1'b1));
      end
   endtask

   task automatic test_register_extremes();
      begin
         // no display: init gives nothing, other modes still go out
         apply_settings(7'd0, 1'b0, 1'b0);
         send_request(make_request(MODE_COMMAND, 8'hA5, any_byte(), any_byte(), 1'b0));
         send_request(make_request(MODE_INIT, any_byte(), any_byte(), any_byte(), 1'b1));
         send_request(make_request(MODE_CHAR, 8'h3C, any_byte(), any_byte(), 1'b1));
         apply_settings(7'd127, 1'b1, 1'b1);
         send_request(make_request(MODE_INIT, any_byte(), any_byte(), any_byte(), 1'b1));
         send_request(make_request(MODE_CURSOR, any_byte(), 8'd2, 8'hEC, 1'b1));
         apply_settings(7'h55, 1'b0, 1'b1);
         send_request(make_request(MODE_INIT, any_byte(), any_byte(), any_byte(), 1'b0));
      end
   endtask

   task automatic test_random_traffic();
      req_type    r;
      logic [6:0] addr;
      begin
         for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct    = (phase == 0) ? 22 : (phase == 1) ? 64 : 0;
            receiver_stall_pct = (phase == 0) ? 64 : (phase == 1) ? 22 : 0;
            for (int step = 0; step < 2; step++) begin
               case ($urandom_range(3))
                  0:       addr = 7'd0;
                  1:       addr = 7'd127;
                  default: addr = 7'($urandom_range(127));
               endcase
               apply_settings(addr, 1'($urandom_range(1)),
                              ($urandom_range(3) != 0));
               for (int n = 0; n < ITEMS_PER_STEP; n++) begin
                  r.mode       = mode_type'($urandom_range(3));
                  r.value      = any_byte();
                  r.row        = $urandom_range(1) ? 8'($urandom_range(4)) : any_byte();
                  r.column     = any_byte();
                  r.deep_clear = 1'($urandom_range(1));
                  send_request(r);
                  if ($urandom_range(39) == 0)
                     wait_for_drain();
               end
            end
         end
      end
   endtask

   initial begin
      sender_idle_pct    = 22;
      receiver_stall_pct = 64;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_settings();
      test_register_extremes();
      test_random_traffic();

      wait_for_drain();
      if (expected_packets.size() != 0) begin
         $error("%0d packet words never arrived", expected_packets.size());
         error_count++;
      end

      $display("covered %0d command, %0d character, %0d cursor and %0d init requests",
               requests_by_mode[MODE_COMMAND], requests_by_mode[MODE_CHAR],
               requests_by_mode[MODE_CURSOR], requests_by_mode[MODE_INIT]);
      $display("checked %0d packet words over %0d register settings",
               packets_checked, settings_applied);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
